// ----- rtl/psse_pkg.sv -----
// Shared constants and divider step functions for the pulse strength envelope.
`default_nettype none
package psse_pkg;

  // Timestamp bits that take part in the phase computation.
  localparam int TIME_BITS = 32;

  // Configuration register indexes.
  localparam logic [1:0] REG_PULSE_ON = 2'd0;
  localparam logic [1:0] REG_PERIOD   = 2'd1;
  localparam logic [1:0] REG_BASE     = 2'd2;

  // Q16 angle and envelope constants.
  localparam logic [18:0] FULL_TURN_Q16 = 19'd411774;
  localparam logic [17:0] PI_Q16        = 18'd205887;
  localparam logic [16:0] FLOOR_Q16     = 17'd19661;
  localparam logic [15:0] SPAN_Q16      = 16'd45875;
  localparam logic [17:0] HALF_Q16      = 18'd32768;
  localparam logic [8:0]  SAT_MAX       = 9'd255;

  // Bhaskara denominator at x = 0: (5 * pi * pi) >> 16.
  localparam logic [63:0] DEN_FULL64 = (64'd5 * 64'd205887 * 64'd205887) >> 16;
  localparam logic [21:0] DEN_FULL   = DEN_FULL64[21:0];

  // Quotient bit counts of the two angle/sine dividers.
  localparam int ANG_QBITS = 19;
  localparam int SIN_QBITS = 18;

  // One restoring step with a 16-bit divisor; bit 16 of the result is the quotient bit.
  function automatic logic [16:0] div_step16(input logic [15:0] rem, input logic b,
                                             input logic [15:0] d);
    logic [16:0] r;
    r = {rem, b};
    if (r >= {1'b0, d}) begin
      return {1'b1, 16'(r - {1'b0, d})};
    end
    return {1'b0, r[15:0]};
  endfunction

  // One restoring step with a 22-bit divisor and a zero shifted in.
  function automatic logic [22:0] div_step22(input logic [21:0] rem, input logic [21:0] d);
    logic [22:0] r;
    r = {rem, 1'b0};
    if (r >= {1'b0, d}) begin
      return {1'b1, 22'(r - {1'b0, d})};
    end
    return {1'b0, r[21:0]};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/psse_phase.sv -----
// Pipelined remainder of the timestamp by the period, one bit per stage.
`default_nettype none
module psse_phase (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           valid_i,
  input  wire logic [psse_pkg::TIME_BITS-1:0] t_i,
  input  wire logic [15:0]                    period_i,
  output logic                                valid_o,
  output logic [15:0]                         phase_o
);
  localparam int N = psse_pkg::TIME_BITS;

  logic [N-1:0]  v_q;
  logic [15:0]   rem_q [N];
  logic [N-1:0]  t_q   [N];
  logic [16:0]   step0;

  assign step0 = psse_pkg::div_step16(16'd0, t_i[N-1], period_i);

  // Valid bits move with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N-2:0], valid_i};
    end
  end

  // Each stage brings down one dividend bit and subtracts the period if it fits.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= step0[15:0];
      t_q[0]   <= t_i << 1;
      for (int k = 1; k < N; k++) begin
        rem_q[k] <= 16'(psse_pkg::div_step16(rem_q[k-1], t_q[k-1][N-1], period_i));
        t_q[k]   <= t_q[k-1] << 1;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign phase_o = rem_q[N-1];
endmodule
`default_nettype wire

// ----- rtl/psse_angle.sv -----
// Phase to Q16 angle: multiply by two pi, then a pipelined divide by the period.
`default_nettype none
module psse_angle (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [15:0] phase_i,
  input  wire logic [15:0] period_i,
  output logic             valid_o,
  output logic [18:0]      angle_o
);
  localparam int Q = psse_pkg::ANG_QBITS;

  logic         mv_q;
  logic [34:0]  prod_q;
  logic [Q-1:0] v_q;
  logic [15:0]  rem_q [Q];
  logic [Q-1:0] low_q [Q];
  logic [Q-1:0] quo_q [Q];
  logic [16:0]  stp   [Q];

  // Restoring step of every stage. The quotient stays below two pi, so the top 16
  // dividend bits are already below the period.
  always_comb begin
    stp[0] = psse_pkg::div_step16(prod_q[34:Q], prod_q[Q-1], period_i);
    for (int k = 1; k < Q; k++) begin
      stp[k] = psse_pkg::div_step16(rem_q[k-1], low_q[k-1][Q-1], period_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
      v_q  <= '0;
    end else if (en_i) begin
      mv_q <= valid_i;
      v_q  <= {v_q[Q-2:0], mv_q};
    end
  end

  // Multiply stage followed by one quotient bit per stage.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= {19'd0, phase_i} * {16'd0, psse_pkg::FULL_TURN_Q16};
      rem_q[0] <= stp[0][15:0];
      low_q[0] <= prod_q[Q-1:0] << 1;
      quo_q[0] <= {{(Q-1){1'b0}}, stp[0][16]};
      for (int k = 1; k < Q; k++) begin
        rem_q[k] <= stp[k][15:0];
        low_q[k] <= low_q[k-1] << 1;
        quo_q[k] <= {quo_q[k-1][Q-2:0], stp[k][16]};
      end
    end
  end

  assign valid_o = v_q[Q-1];
  assign angle_o = quo_q[Q-1];
endmodule
`default_nettype wire

// ----- rtl/psse_sine.sv -----
// Bhaskara sine magnitude: fold, numerator term, denominator and a pipelined divide.
`default_nettype none
module psse_sine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [18:0] angle_i,
  output logic             valid_o,
  output logic             neg_o,
  output logic [17:0]      abs_sin_o
);
  localparam int Q = psse_pkg::SIN_QBITS;

  logic [2:0]   pv_q;
  logic         neg1_q, neg2_q, neg3_q;
  logic [17:0]  x_q;
  logic [17:0]  xpm_q;
  logic [21:0]  den_q;
  logic [19:0]  num_q;
  logic [35:0]  xprod;
  logic         fold;
  logic [Q-1:0] v_q;
  logic [Q-1:0] neg_q;
  logic [21:0]  rem_q [Q];
  logic [21:0]  den_s [Q];
  logic [Q-1:0] quo_q [Q];
  logic [22:0]  stp   [Q];

  assign fold  = angle_i > {1'b0, psse_pkg::PI_Q16};
  assign xprod = {18'd0, x_q} * {18'd0, 18'(psse_pkg::PI_Q16 - x_q)};

  // Restoring step of every divider stage.
  always_comb begin
    stp[0] = psse_pkg::div_step22({2'b00, num_q}, den_q);
    for (int k = 1; k < Q; k++) begin
      stp[k] = psse_pkg::div_step22(rem_q[k-1], den_s[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
      v_q  <= '0;
    end else if (en_i) begin
      pv_q <= {pv_q[1:0], valid_i};
      v_q  <= {v_q[Q-2:0], pv_q[2]};
    end
  end

  // Fold the second half period, form x*(pi-x), then the denominator.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= fold;
      x_q    <= fold ? 18'(angle_i - {1'b0, psse_pkg::PI_Q16}) : angle_i[17:0];
      neg2_q <= neg1_q;
      xpm_q  <= xprod[33:16];
      neg3_q <= neg2_q;
      den_q  <= psse_pkg::DEN_FULL - {2'b00, xpm_q, 2'b00};
      num_q  <= {xpm_q, 2'b00};
    end
  end

  // (xpm << 20) / den, one quotient bit per stage; the low dividend bits are zero.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= stp[0][21:0];
      den_s[0] <= den_q;
      quo_q[0] <= {{(Q-1){1'b0}}, stp[0][22]};
      neg_q[0] <= neg3_q;
      for (int k = 1; k < Q; k++) begin
        rem_q[k] <= stp[k][21:0];
        den_s[k] <= den_s[k-1];
        quo_q[k] <= {quo_q[k-1][Q-2:0], stp[k][22]};
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  assign valid_o   = v_q[Q-1];
  assign neg_o     = neg_q[Q-1];
  assign abs_sin_o = quo_q[Q-1];
endmodule
`default_nettype wire

// ----- rtl/pulse_strength_sine_envelope.sv -----
// Top level: configuration registers, envelope scaling and output register.
// Usage:
//   Input channel in_valid_i/in_ready_o carries one timestamp beat now_ms_i.
//   Output channel out_valid_o/out_ready_i carries one strength beat
//   strength_out_o for each input beat, in order.
//   Configuration registers are written through cfg_we_i, cfg_idx_i and
//   cfg_data_i while no beat is in flight.
// From input acceptance to output valid a beat passes 32 stages of
// the timestamp remainder, a multiply and 19 divider stages for the angle,
// three stages plus 18 divider stages for the sine, two scaling stages and
// the output register. A new beat is accepted every cycle unless stalled.
// When the receiver stalls, the whole pipeline holds; in_ready_o is low
// exactly while the output register is full and not being taken.
// Reset clears all valid bits and sets pulse off, period 0 and base
// strength 255.
`default_nettype none
module pulse_strength_sine_envelope (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [31:0]                    now_ms_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [7:0]                          strength_out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [1:0]                     cfg_idx_i,
  input  wire logic [15:0]                    cfg_data_i
);
  localparam int TB = psse_pkg::TIME_BITS;

  logic        pulse_on_q;
  logic [15:0] period_q;
  logic [7:0]  base_q;
  logic        en;
  logic        ph_v, an_v, sn_v, neg;
  logic [15:0] phase;
  logic [18:0] angle;
  logic [17:0] abs_sin;
  logic [17:0] sub;
  logic        p_v_q, b_v_q;
  logic [16:0] p_q;
  logic [16:0] env_q;
  logic [32:0] span_prod;
  logic [24:0] scale_prod;
  logic [8:0]  res;
  logic        out_v_q;
  logic [7:0]  out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_on_q <= 1'b0;
      period_q   <= 16'd0;
      base_q     <= 8'd255;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        psse_pkg::REG_PULSE_ON: pulse_on_q <= cfg_data_i[0];
        psse_pkg::REG_PERIOD:   period_q   <= cfg_data_i;
        psse_pkg::REG_BASE:     base_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the output register can take a beat.
  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  psse_phase u_phase (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .t_i      (now_ms_i[TB-1:0]),
    .period_i (period_q),
    .valid_o  (ph_v),
    .phase_o  (phase)
  );

  psse_angle u_angle (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (ph_v),
    .phase_i  (phase),
    .period_i (period_q),
    .valid_o  (an_v),
    .angle_o  (angle)
  );

  psse_sine u_sine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (an_v),
    .angle_i   (angle),
    .valid_o   (sn_v),
    .neg_o     (neg),
    .abs_sin_o (abs_sin)
  );

  // Halved sine around one half; the negative half rounds toward minus infinity.
  assign sub        = 18'((19'(abs_sin) + 19'd1) >> 1);
  assign span_prod  = {17'd0, psse_pkg::SPAN_Q16} * {16'd0, p_q};
  assign scale_prod = {17'd0, base_q} * {8'd0, env_q};
  assign res        = (scale_prod[24:16] > psse_pkg::SAT_MAX) ? psse_pkg::SAT_MAX
                                                              : scale_prod[24:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      p_v_q   <= sn_v;
      b_v_q   <= p_v_q;
      out_v_q <= b_v_q;
    end
  end

  // Phase term, envelope factor, then the scaled and saturated strength.
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (neg) begin
        p_q <= (sub > psse_pkg::HALF_Q16) ? 17'd0 : 17'(psse_pkg::HALF_Q16 - sub);
      end else begin
        p_q <= 17'(psse_pkg::HALF_Q16 + {1'b0, abs_sin[17:1]});
      end
      env_q <= 17'(psse_pkg::FLOOR_Q16 + span_prod[32:16]);
      if (!pulse_on_q || period_q == 16'd0) begin
        out_q <= base_q;
      end else begin
        out_q <= res[7:0];
      end
    end
  end

  assign out_valid_o    = out_v_q;
  assign strength_out_o = out_q;
endmodule
`default_nettype wire
